>>> hdl/cts_pkg.sv
// Shared constants and types for the comment stripper.
package cts_pkg;

   // Character codes.
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // One input byte yields at most this many output bytes.
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = 2;

   // Default output queue depth; must hold at least MAX_RESULTS + 1.
   localparam int QUEUE_DEPTH = 8;

   typedef enum logic [8:0] {
      MODE_NORMAL     = 9'b000000001,
      MODE_SPACE      = 9'b000000010,
      MODE_SLASH      = 9'b000000100,
      MODE_ESCAPE     = 9'b000001000,
      MODE_STRING     = 9'b000010000,
      MODE_STR_ESCAPE = 9'b000100000,
      MODE_BLOCK      = 9'b001000000,
      MODE_BLOCK_STAR = 9'b010000000,
      MODE_LINE       = 9'b100000000
   } scan_mode_type;

   // One output transaction as stored in the queue.
   typedef struct packed {
      logic       end_of_text;
      logic [7:0] out_byte;
   } entry_type;

   // Results of one input byte, handed from the filter to the queue.
   typedef struct packed {
      logic [RES_CNT_W-1:0]             count;
      entry_type [MAX_RESULTS-1:0]      entries;
   } result_type;

endpackage

>>> hdl/cts_filter.sv
// Scanner state and the per-byte filtering logic.
module cts_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          text_byte,
   input  logic                final_byte,
   output cts_pkg::result_type result
);

   typedef struct packed {
      cts_pkg::scan_mode_type                  mode;
      logic [7:0]                              last;
      logic                                    any;
      logic [cts_pkg::RES_CNT_W-1:0]           cnt;
      cts_pkg::entry_type [cts_pkg::MAX_RESULTS-1:0] slots;
   } ctx_type;

   localparam logic [cts_pkg::RES_CNT_W-1:0] CNT_FULL =
      cts_pkg::RES_CNT_W'(cts_pkg::MAX_RESULTS);

   cts_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]             last_ff, last_in;
   logic                   any_ff, any_in;

   function automatic ctx_type put_byte(input ctx_type c, input logic [7:0] b);
      ctx_type r;
      r = c;
      if (c.cnt != CNT_FULL) begin
         r.slots[c.cnt].out_byte    = b;
         r.slots[c.cnt].end_of_text = 1'b0;
         r.cnt  = c.cnt + 1'b1;
         r.last = b;
         r.any  = 1'b1;
      end
      return r;
   endfunction

   function automatic ctx_type line_end(input ctx_type c);
      ctx_type r;
      r = c;
      if (c.any && (c.last != cts_pkg::CH_CR)) begin
         r = put_byte(r, cts_pkg::CH_CR);
      end
      r.mode = cts_pkg::MODE_NORMAL;
      return r;
   endfunction

   function automatic ctx_type plain(input ctx_type c, input logic [7:0] b);
      ctx_type r;
      r = c;
      r.mode = cts_pkg::MODE_NORMAL;
      unique case (b)
         cts_pkg::CH_BSL: begin
            r = put_byte(r, b);
            r.mode = cts_pkg::MODE_ESCAPE;
         end
         cts_pkg::CH_QUOTE: begin
            r = put_byte(r, b);
            r.mode = cts_pkg::MODE_STRING;
         end
         cts_pkg::CH_CR, cts_pkg::CH_LF: r = line_end(r);
         cts_pkg::CH_SP, cts_pkg::CH_TAB: r.mode = cts_pkg::MODE_SPACE;
         cts_pkg::CH_SLASH: r.mode = cts_pkg::MODE_SLASH;
         cts_pkg::CH_HASH: r.mode = cts_pkg::MODE_LINE;
         default: r = put_byte(r, b);
      endcase
      return r;
   endfunction

   ctx_type c;
   logic    is_nl;
   logic    is_ws;

   always_comb begin
      is_nl = (text_byte == cts_pkg::CH_CR) || (text_byte == cts_pkg::CH_LF);
      is_ws = (text_byte == cts_pkg::CH_SP) || (text_byte == cts_pkg::CH_TAB);
      c       = '0;
      c.mode  = mode_ff;
      c.last  = last_ff;
      c.any   = any_ff;

      unique case (mode_ff)
         cts_pkg::MODE_NORMAL: c = plain(c, text_byte);
         cts_pkg::MODE_SPACE: begin
            if (is_nl) begin
               c = line_end(c);
            end else if (!is_ws) begin
               // pending space is emitted only after real text, never doubled
               if (c.any && (c.last != cts_pkg::CH_SP)) begin
                  c = put_byte(c, cts_pkg::CH_SP);
               end
               c = plain(c, text_byte);
            end
         end
         cts_pkg::MODE_SLASH: begin
            if (text_byte == cts_pkg::CH_STAR) begin
               c.mode = cts_pkg::MODE_BLOCK;
            end else if (text_byte == cts_pkg::CH_SLASH) begin
               c.mode = cts_pkg::MODE_LINE;
            end else begin
               c = put_byte(c, cts_pkg::CH_SLASH);
               c = plain(c, text_byte);
            end
         end
         cts_pkg::MODE_ESCAPE: begin
            c = put_byte(c, text_byte);
            c.mode = cts_pkg::MODE_NORMAL;
         end
         cts_pkg::MODE_STRING: begin
            c = put_byte(c, text_byte);
            if (text_byte == cts_pkg::CH_QUOTE) begin
               c.mode = cts_pkg::MODE_NORMAL;
            end else if (text_byte == cts_pkg::CH_BSL) begin
               c.mode = cts_pkg::MODE_STR_ESCAPE;
            end
         end
         cts_pkg::MODE_STR_ESCAPE: begin
            c = put_byte(c, text_byte);
            c.mode = cts_pkg::MODE_STRING;
         end
         cts_pkg::MODE_BLOCK: begin
            if (text_byte == cts_pkg::CH_STAR) begin
               c.mode = cts_pkg::MODE_BLOCK_STAR;
            end
         end
         cts_pkg::MODE_BLOCK_STAR: begin
            if (text_byte == cts_pkg::CH_SLASH) begin
               c.mode = cts_pkg::MODE_NORMAL;
            end else if (text_byte != cts_pkg::CH_STAR) begin
               c.mode = cts_pkg::MODE_BLOCK;
            end
         end
         cts_pkg::MODE_LINE: begin
            if (is_nl) begin
               c = line_end(c);
            end
         end
         default: c = plain(c, text_byte);
      endcase

      if (final_byte) begin
         // flush a pending slash, then the terminator; state goes back to reset
         if (c.mode == cts_pkg::MODE_SLASH) begin
            c = put_byte(c, cts_pkg::CH_SLASH);
         end
         if (c.cnt != CNT_FULL) begin
            c.slots[c.cnt].out_byte    = cts_pkg::CH_NUL;
            c.slots[c.cnt].end_of_text = 1'b1;
            c.cnt = c.cnt + 1'b1;
         end
         c.mode = cts_pkg::MODE_NORMAL;
         c.last = 8'h00;
         c.any  = 1'b0;
      end

      mode_in = c.mode;
      last_in = c.last;
      any_in  = c.any;
      result.count   = c.cnt;
      result.entries = c.slots;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cts_pkg::MODE_NORMAL;
         last_ff <= 8'h00;
         any_ff  <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         last_ff <= last_in;
         any_ff  <= any_in;
      end
   end

endmodule

>>> hdl/cts_out_queue.sv
// Output queue: takes up to three a cycle, drains one a cycle on pop.
module cts_out_queue #(
   parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  cts_pkg::result_type push,
   output logic                has_room,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cts_pkg::entry_type  pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int NRES  = cts_pkg::MAX_RESULTS;
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - NRES);
   localparam logic [PTR_W:0]   DEPTH_EXT  = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

   cts_pkg::entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NRES-1:0][PTR_W-1:0] slot_idx;
   logic [PTR_W:0]   sum;
   logic             pop;

   // wrap a pointer plus a small offset (offset below DEPTH)
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, p} + off;
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[PTR_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < NRES; i++) begin
         slot_idx[i] = wrap_add(wr_ptr_ff, (PTR_W + 1)'(i));
      end
      sum       = (PTR_W + 1)'(push.count);
      wr_ptr_in = wrap_add(wr_ptr_ff, sum);
      pop_valid = (count_ff != '0);
      pop       = pop_valid && pop_ready;
      rd_ptr_in = pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
      has_room  = (count_ff <= ROOM_LIMIT);
      pop_entry = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NRES; i++) begin
         if (push.count > cts_pkg::RES_CNT_W'(i)) begin
            mem[slot_idx[i]] <= push.entries[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/config_text_comment_stripper_core.sv
// Top level of the text comment stripper: input register, filter, output queue.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+----------
//   req     | in        | req_text_byte[7:0], req_final_byte      | valid/ready
//   rsp     | out       | rsp_out_byte[7:0], rsp_end_of_text      | valid/ready
//
// One text byte per clock in steady state. A transaction is held in the input
// register, where the filter turns it into zero to three output bytes that are
// written into the output queue when the held byte moves on; the first output
// is valid once the queue has registered it. The queue drains one transaction
// per clock while rsp_ready is high. A held byte moves on only while the queue
// has at least three free entries, so when the receiver stalls or bytes expand
// faster than they drain, req_ready drops with the register full.
// Reset (synchronous, active high) empties the queue and the input register
// and returns the scanner to normal text mode with nothing emitted.
module config_text_comment_stripper_core #(
   parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_text
);

   // input register
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_final_ff;

   cts_pkg::result_type filt_result;
   cts_pkg::result_type push;
   cts_pkg::entry_type  head;
   logic                has_room;
   logic                advance;
   logic                req_fire;

   // the held byte moves on once the queue can take its worst case
   assign advance   = stage_valid_ff && has_room;
   assign req_ready = !stage_valid_ff || has_room;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      push       = filt_result;
      push.count = advance ? filt_result.count : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff  <= req_text_byte;
         stage_final_ff <= req_final_byte;
      end
   end

   cts_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .text_byte  (stage_byte_ff),
      .final_byte (stage_final_ff),
      .result     (filt_result)
   );

   cts_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_entry (head)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_end_of_text = head.end_of_text;

endmodule

>>> dv/config_text_comment_stripper_core_tb.sv
// Self-checking testbench for the text comment stripper: directed and random texts.
module config_text_comment_stripper_core_tb;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 80;
   localparam int FULL_RATE_ITEMS = 40;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic [7:0] SPECIAL_CHARS [10] = '{
      cts_pkg::CH_CR, cts_pkg::CH_LF, cts_pkg::CH_TAB, cts_pkg::CH_SP, cts_pkg::CH_HASH,
      cts_pkg::CH_STAR, cts_pkg::CH_SLASH, cts_pkg::CH_QUOTE, cts_pkg::CH_BSL,
      cts_pkg::CH_NUL};

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte  = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_of_text;

   // Predictor state: scanner mode, last filtered byte, whether anything went out.
   cts_pkg::scan_mode_type strip_mode = cts_pkg::MODE_NORMAL;
   logic [7:0]             last_out   = 8'h00;
   logic                   any_out    = 1'b0;
   int                     step_count;

   cts_pkg::entry_type expected_out_q [$];
   logic [7:0]         text_buf [$];
   int                 items_sent  = 0;
   int                 error_count = 0;
   int                 cycle_count = 0;

   // Idle controls for the sender and the receiver process.
   bit req_gaps_on    = 1'b1;
   bit rsp_stalls_on  = 1'b1;
   bit hold_off_start = 1'b0;

   config_text_comment_stripper_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_end_of_text (rsp_end_of_text)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void emit_char(input logic [7:0] c);
      cts_pkg::entry_type e;
      if (step_count >= cts_pkg::MAX_RESULTS) return;
      e.out_byte    = c;
      e.end_of_text = 1'b0;
      expected_out_q.push_back(e);
      step_count++;
      last_out = c;
      any_out  = 1'b1;
   endfunction

   // CR/LF runs collapse into one CR, never leading.
   function automatic void emit_line_end();
      if (any_out && last_out != cts_pkg::CH_CR) emit_char(cts_pkg::CH_CR);
      strip_mode = cts_pkg::MODE_NORMAL;
   endfunction

   function automatic void take_plain(input logic [7:0] c);
      strip_mode = cts_pkg::MODE_NORMAL;
      case (c)
         cts_pkg::CH_BSL: begin
            emit_char(c);
            strip_mode = cts_pkg::MODE_ESCAPE;
         end
         cts_pkg::CH_QUOTE: begin
            emit_char(c);
            strip_mode = cts_pkg::MODE_STRING;
         end
         cts_pkg::CH_CR, cts_pkg::CH_LF:  emit_line_end();
         cts_pkg::CH_SP, cts_pkg::CH_TAB: strip_mode = cts_pkg::MODE_SPACE;
         cts_pkg::CH_SLASH:               strip_mode = cts_pkg::MODE_SLASH;
         cts_pkg::CH_HASH:                strip_mode = cts_pkg::MODE_LINE;
         default:                         emit_char(c);
      endcase
   endfunction

   function automatic void strip_step(input logic [7:0] c, input logic fin);
      logic               is_eol;
      cts_pkg::entry_type term;
      step_count = 0;
      is_eol     = (c == cts_pkg::CH_CR) || (c == cts_pkg::CH_LF);
      case (strip_mode)
         cts_pkg::MODE_NORMAL: take_plain(c);
         cts_pkg::MODE_SPACE: begin
            if (is_eol) begin
               emit_line_end();
            end else if (c != cts_pkg::CH_SP && c != cts_pkg::CH_TAB) begin
               if (any_out && last_out != cts_pkg::CH_SP) emit_char(cts_pkg::CH_SP);
               take_plain(c);
            end
         end
         cts_pkg::MODE_SLASH: begin
            if (c == cts_pkg::CH_STAR) begin
               strip_mode = cts_pkg::MODE_BLOCK;
            end else if (c == cts_pkg::CH_SLASH) begin
               strip_mode = cts_pkg::MODE_LINE;
            end else begin
               emit_char(cts_pkg::CH_SLASH);
               take_plain(c);
            end
         end
         cts_pkg::MODE_ESCAPE: begin
            emit_char(c);
            strip_mode = cts_pkg::MODE_NORMAL;
         end
         cts_pkg::MODE_STRING: begin
            emit_char(c);
            if (c == cts_pkg::CH_QUOTE) strip_mode = cts_pkg::MODE_NORMAL;
            else if (c == cts_pkg::CH_BSL) strip_mode = cts_pkg::MODE_STR_ESCAPE;
         end
         cts_pkg::MODE_STR_ESCAPE: begin
            emit_char(c);
            strip_mode = cts_pkg::MODE_STRING;
         end
         cts_pkg::MODE_BLOCK: begin
            if (c == cts_pkg::CH_STAR) strip_mode = cts_pkg::MODE_BLOCK_STAR;
         end
         cts_pkg::MODE_BLOCK_STAR: begin
            if (c == cts_pkg::CH_SLASH) strip_mode = cts_pkg::MODE_NORMAL;
            else if (c != cts_pkg::CH_STAR) strip_mode = cts_pkg::MODE_BLOCK;
         end
         cts_pkg::MODE_LINE: begin
            if (is_eol) emit_line_end();
         end
         default: take_plain(c);
      endcase
      // End of text: flush a pending slash, add the terminator, start over.
      if (fin) begin
         if (strip_mode == cts_pkg::MODE_SLASH) emit_char(cts_pkg::CH_SLASH);
         if (step_count < cts_pkg::MAX_RESULTS) begin
            term.out_byte    = cts_pkg::CH_NUL;
            term.end_of_text = 1'b1;
            expected_out_q.push_back(term);
         end
         strip_mode = cts_pkg::MODE_NORMAL;
         last_out   = 8'h00;
         any_out    = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------- idling

   // Mostly short, now and then long.
   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 35);
      return $urandom_range(1, 3);
   endfunction

   // Receiver: random stalls plus an optional long hold-off counted here.
   always @(posedge clock) begin
      int stall_left;
      int hold_left;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (hold_off_start) begin
            hold_left      = HOLD_OFF_CYCLES;
            hold_off_start = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_idle_len() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      cts_pkg::entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out_q.size() == 0) begin
            $display("%0t: unexpected transaction out_byte=%02h end_of_text=%0b",
                     $time, rsp_out_byte, rsp_end_of_text);
            error_count++;
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               $display("%0t: end_of_text expected %0b actual %0b",
                        $time, want.end_of_text, rsp_end_of_text);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- sending

   // Entered at a rising edge; leaves at the acceptance edge or after the gap.
   task automatic send_text_byte(input logic [7:0] c, input logic fin);
      int gap;
      req_valid      <= 1'b1;
      req_text_byte  <= c;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      strip_step(c, fin);
      items_sent++;
      gap = (req_gaps_on && $urandom_range(0, 99) < 45) ? pick_idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text_buf();
      for (int i = 0; i < text_buf.size(); i++)
         send_text_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   function automatic logic [7:0] random_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   // One piece of text: mostly well-formed constructs, some noise and broken ones.
   function automatic void add_fragment();
      int kind;
      kind = $urandom_range(0, 11);
      case (kind)
         0, 1: repeat ($urandom_range(1, 4)) text_buf.push_back(random_letter());
         2: repeat ($urandom_range(1, 3))
               text_buf.push_back($urandom_range(0, 1) ? cts_pkg::CH_SP : cts_pkg::CH_TAB);
         3: repeat ($urandom_range(1, 2))
               text_buf.push_back($urandom_range(0, 1) ? cts_pkg::CH_CR : cts_pkg::CH_LF);
         4: begin
            text_buf.push_back(cts_pkg::CH_SLASH);
            text_buf.push_back(cts_pkg::CH_STAR);
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 4))
                  0:       text_buf.push_back(cts_pkg::CH_STAR);
                  1:       text_buf.push_back(cts_pkg::CH_SLASH);
                  2:       text_buf.push_back(cts_pkg::CH_SP);
                  3:       text_buf.push_back(cts_pkg::CH_LF);
                  default: text_buf.push_back(random_letter());
               endcase
            end
            repeat ($urandom_range(1, 3)) text_buf.push_back(cts_pkg::CH_STAR);
            text_buf.push_back(cts_pkg::CH_SLASH);
         end
         5: begin
            if ($urandom_range(0, 1)) begin
               text_buf.push_back(cts_pkg::CH_HASH);
            end else begin
               text_buf.push_back(cts_pkg::CH_SLASH);
               text_buf.push_back(cts_pkg::CH_SLASH);
            end
            repeat ($urandom_range(0, 3))
               text_buf.push_back($urandom_range(0, 2) ? random_letter() : cts_pkg::CH_QUOTE);
            text_buf.push_back($urandom_range(0, 1) ? cts_pkg::CH_CR : cts_pkg::CH_LF);
         end
         6: begin
            text_buf.push_back(cts_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 4))
                  0: begin
                     text_buf.push_back(cts_pkg::CH_BSL);
                     text_buf.push_back(8'($urandom_range(0, 255)));
                  end
                  1:       text_buf.push_back(cts_pkg::CH_SP);
                  2:       text_buf.push_back(cts_pkg::CH_HASH);
                  3:       text_buf.push_back(cts_pkg::CH_SLASH);
                  default: text_buf.push_back(random_letter());
               endcase
            end
            text_buf.push_back(cts_pkg::CH_QUOTE);
         end
         7: begin
            text_buf.push_back(cts_pkg::CH_BSL);
            text_buf.push_back(8'($urandom_range(0, 255)));
         end
         8: begin
            text_buf.push_back(cts_pkg::CH_SLASH);
            text_buf.push_back(random_letter());
         end
         9: repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
         10: begin
            // unterminated openers
            case ($urandom_range(0, 3))
               0: text_buf.push_back(cts_pkg::CH_SLASH);
               1: begin
                  text_buf.push_back(cts_pkg::CH_SLASH);
                  text_buf.push_back(cts_pkg::CH_STAR);
               end
               2:       text_buf.push_back(cts_pkg::CH_QUOTE);
               default: text_buf.push_back(cts_pkg::CH_BSL);
            endcase
         end
         default: text_buf.push_back(SPECIAL_CHARS[$urandom_range(0, 9)]);
      endcase
   endfunction

   task automatic send_random_text();
      text_buf.delete();
      repeat ($urandom_range(1, 5)) add_fragment();
      send_text_buf();
   endtask

   // ---------------------------------------------------------------- tests

   // Zero and 0xFF pass through; a slash pending at the end is flushed.
   task automatic test_byte_extremes();
      text_buf = '{cts_pkg::CH_NUL, 8'hFF, cts_pkg::CH_SLASH};
      send_text_buf();
   endtask

   // Leading space/CR dropped, runs collapsed, space before line end dropped.
   task automatic test_whitespace();
      text_buf = '{cts_pkg::CH_SP, cts_pkg::CH_CR, "a", cts_pkg::CH_TAB, cts_pkg::CH_SP,
                   "b", cts_pkg::CH_SP, cts_pkg::CH_LF, cts_pkg::CH_CR, "c", cts_pkg::CH_SP};
      send_text_buf();
   endtask

   // Star run closing a block, slash-slash comment right after it, line ends of
   // that and a hash comment collapsed to one CR, lone slash ahead of the final byte.
   task automatic test_comments();
      text_buf = '{"x", cts_pkg::CH_SLASH, cts_pkg::CH_STAR, cts_pkg::CH_STAR,
                   cts_pkg::CH_STAR, cts_pkg::CH_SLASH, cts_pkg::CH_SLASH, cts_pkg::CH_SLASH,
                   cts_pkg::CH_LF, cts_pkg::CH_HASH, cts_pkg::CH_CR, cts_pkg::CH_SLASH, "c"};
      send_text_buf();
   endtask

   // Comment markers inside quotes, escaped quote, escape outside quotes,
   // escape left pending at the end.
   task automatic test_quoting();
      text_buf = '{cts_pkg::CH_QUOTE, cts_pkg::CH_HASH, cts_pkg::CH_BSL, cts_pkg::CH_QUOTE,
                   cts_pkg::CH_QUOTE, cts_pkg::CH_BSL, cts_pkg::CH_HASH, cts_pkg::CH_BSL};
      send_text_buf();
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_full_rate();
      int start;
      start         = items_sent;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      while (items_sent - start < FULL_RATE_ITEMS) send_random_text();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering: queue fills, input stalls.
   task automatic test_backpressure();
      hold_off_start = 1'b1;
      req_gaps_on    = 1'b0;
      text_buf.delete();
      repeat (40) text_buf.push_back(random_letter());
      send_text_buf();
      req_gaps_on = 1'b1;
   endtask

   // Sender goes quiet until every outstanding transaction has drained.
   task automatic test_drain_pause();
      send_random_text();
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      send_random_text();
   endtask

   task automatic test_random_texts();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // occasional stretches where one side never idles
         req_gaps_on   = $urandom_range(0, 3) != 0;
         rsp_stalls_on = $urandom_range(0, 3) != 0;
         send_random_text();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_byte_extremes();
      test_whitespace();
      test_comments();
      test_quoting();
      test_full_rate();
      test_backpressure();
      test_drain_pause();
      test_random_texts();
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> config_text_comment_stripper_core.f
hdl/cts_pkg.sv
hdl/cts_filter.sv
hdl/cts_out_queue.sv
hdl/config_text_comment_stripper_core.sv
dv/config_text_comment_stripper_core_tb.sv
